// ----- src/vno_pkg.sv -----
// Shared types and constants of the viewpoint normal orienter.
package vno_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned NORM_W  = 16;
    localparam int unsigned DIFF_W  = COORD_W + 1;
    localparam int unsigned PROD_W  = DIFF_W + NORM_W;
    localparam int unsigned DOT_W   = PROD_W + 2;
    localparam int unsigned AXES    = 3;
    localparam int unsigned MASK_W  = 2;
    localparam int unsigned NCAM_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CAMERAS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_BASE    = 3'd1;

    localparam logic [NCAM_W-1:0] NUM_CAMERAS_RESET = 2'd1;

    localparam logic signed [NORM_W-1:0] NORM_MIN = 16'sh8000;
    localparam logic signed [NORM_W-1:0] NORM_MAX = 16'sh7fff;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NORM_W-1:0]  norm_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DOT_W-1:0]   dot_t;

    // Load strobes of the three lane stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } adv_t;

    // Negate with saturation: the most negative code maps to the largest positive one
    function automatic norm_t neg_sat(input norm_t n);
        norm_t r;
        if (n == NORM_MIN) begin
            r = NORM_MAX;
        end else begin
            r = -n;
        end
        return r;
    endfunction

endpackage

// ----- src/vno_cfg.sv -----
// Configuration register file: camera count and viewpoint coordinates.
module vno_cfg #(
    parameter int unsigned MAX_CAMERAS = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vno_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vno_pkg::COORD_W-1:0]       cfg_data,
    output logic [vno_pkg::NCAM_W-1:0]        num_cameras,
    output vno_pkg::coord_t                   cam_pos [MAX_CAMERAS][vno_pkg::AXES]
);

    logic [vno_pkg::NCAM_W-1:0] num_cameras_reg;
    vno_pkg::coord_t            cam_pos_reg [MAX_CAMERAS][vno_pkg::AXES];

    assign cfg_ready   = 1'b1;
    assign num_cameras = num_cameras_reg;
    assign cam_pos     = cam_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cameras_reg <= vno_pkg::NUM_CAMERAS_RESET;
            for (int j = 0; j < int'(MAX_CAMERAS); j++) begin
                for (int k = 0; k < int'(vno_pkg::AXES); k++) begin
                    cam_pos_reg[j][k] <= '0;
                end
            end
        end else if (cfg_valid) begin
            if (cfg_index == vno_pkg::REG_NUM_CAMERAS) begin
                num_cameras_reg <= cfg_data[vno_pkg::NCAM_W-1:0];
            end
            // Indexes past the list, or of slots beyond MAX_CAMERAS, match nothing: drop them
            for (int j = 0; j < int'(MAX_CAMERAS); j++) begin
                for (int k = 0; k < int'(vno_pkg::AXES); k++) begin
                    if (cfg_index == vno_pkg::CFG_IDX_W'(int'(vno_pkg::REG_CAM_BASE) + 3 * j + k))
                    begin
                        cam_pos_reg[j][k] <= cfg_data;
                    end
                end
            end
        end
    end

endmodule

// ----- src/vno_lane.sv -----
// One camera lane: difference, products and sign of the dot product over three stages.
module vno_lane (
    input  logic            aclk,
    input  vno_pkg::adv_t   adv,
    input  vno_pkg::coord_t point [vno_pkg::AXES],
    input  vno_pkg::coord_t cam   [vno_pkg::AXES],
    input  vno_pkg::norm_t  normal_s1 [vno_pkg::AXES],
    output logic            dot_neg
);

    vno_pkg::diff_t diff_reg [vno_pkg::AXES];
    vno_pkg::prod_t prod_reg [vno_pkg::AXES];
    logic           dot_neg_reg;
    vno_pkg::dot_t  dot_sum;

    always_ff @(posedge aclk) begin
        for (int k = 0; k < int'(vno_pkg::AXES); k++) begin
            if (adv.s1) begin
                diff_reg[k] <= vno_pkg::diff_t'(point[k]) - vno_pkg::diff_t'(cam[k]);
            end
            if (adv.s2) begin
                prod_reg[k] <= vno_pkg::prod_t'(normal_s1[k]) * vno_pkg::prod_t'(diff_reg[k]);
            end
        end
    end

    assign dot_sum = vno_pkg::dot_t'(prod_reg[0]) + vno_pkg::dot_t'(prod_reg[1])
                   + vno_pkg::dot_t'(prod_reg[2]);

    always_ff @(posedge aclk) begin
        if (adv.s3) begin
            dot_neg_reg <= dot_sum[vno_pkg::DOT_W-1];
        end
    end

    assign dot_neg = dot_neg_reg;

endmodule

// ----- src/viewpoint_normal_orienter.sv -----
// Top level of the viewpoint normal orienter: four-stage stream pipeline.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------------------
//  s_      | in  | s_tvalid / s_tready     | point xyz Q16.16, normal xyz Q1.15, seen mask
//  m_      | out | m_tvalid / m_tready     | oriented normal xyz Q1.15, reversed flag
//  cfg_    | in  | cfg_valid / cfg_ready   | register index, 32-bit write data
//
//  One point enters per cycle while m_ does not stall; its result is registered in turn
//  in the difference, products, dot sign and output registers. The 16x33 multiply per axis
//  and lane sets the stage depth.
//  Synchronous active-low reset clears all valid bits and loads the register defaults.
//  Each stage advances when the next one is empty or advancing, so a stall on m_
//  holds every full stage and bubbles still close up behind it.
module viewpoint_normal_orienter #(
    parameter int unsigned MAX_CAMERAS = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input points
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] point_x, [63:32] point_y, [95:64] point_z,
    // [111:96] nrm_x, [127:112] nrm_y, [143:128] nrm_z
    input  logic [143:0]                   s_tdata,
    // [1:0] seen_mask
    input  logic [vno_pkg::MASK_W-1:0]     s_tuser,
    // Oriented normals
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] out_nrm_x, [31:16] out_nrm_y, [47:32] out_nrm_z
    output logic [47:0]                    m_tdata,
    // [0] was_reversed
    output logic                           m_tuser,
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vno_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vno_pkg::COORD_W-1:0]    cfg_data
);

    logic [vno_pkg::NCAM_W-1:0] num_cameras;
    vno_pkg::coord_t            cam_pos [MAX_CAMERAS][vno_pkg::AXES];

    vno_pkg::coord_t point [vno_pkg::AXES];
    vno_pkg::norm_t  normal_in [vno_pkg::AXES];

    // Per-stage valid bits, normals and lane enables
    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    vno_pkg::norm_t         n1_reg [vno_pkg::AXES];
    vno_pkg::norm_t         n2_reg [vno_pkg::AXES];
    vno_pkg::norm_t         n3_reg [vno_pkg::AXES];
    logic [MAX_CAMERAS-1:0] en_in, en1_reg, en2_reg, en3_reg;
    logic [MAX_CAMERAS-1:0] lane_neg;

    logic [47:0]            out_data_reg;
    logic                   out_rev_reg;
    logic                   ready1, ready2, ready3, ready4;
    logic                   facing;
    vno_pkg::adv_t          adv;

    vno_cfg #(
        .MAX_CAMERAS (MAX_CAMERAS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .num_cameras (num_cameras),
        .cam_pos     (cam_pos)
    );

    // Unpack the input transfer
    assign point[0]     = s_tdata[31:0];
    assign point[1]     = s_tdata[63:32];
    assign point[2]     = s_tdata[95:64];
    assign normal_in[0] = s_tdata[111:96];
    assign normal_in[1] = s_tdata[127:112];
    assign normal_in[2] = s_tdata[143:128];

    // A lane counts only if the camera is in use and sees the point; a count above
    // MAX_CAMERAS saturates because no lane beyond it exists.
    for (genvar j = 0; j < int'(MAX_CAMERAS); j++) begin : g_en
        assign en_in[j] = (num_cameras > vno_pkg::NCAM_W'(j)) && s_tuser[j];
    end

    // Ready chain: a stage takes new data when empty or when it hands its own onward
    assign ready4   = !v4_reg || m_tready;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;

    assign adv.s1 = ready1;
    assign adv.s2 = ready2;
    assign adv.s3 = ready3;

    for (genvar j = 0; j < int'(MAX_CAMERAS); j++) begin : g_lane
        vno_lane u_lane (
            .aclk      (aclk),
            .adv       (adv),
            .point     (point),
            .cam       (cam_pos[j]),
            .normal_s1 (n1_reg),
            .dot_neg   (lane_neg[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_tvalid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
            if (ready4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Payload stages carry no reset; they load whenever their stage may advance
    always_ff @(posedge aclk) begin
        if (ready1) begin
            n1_reg  <= normal_in;
            en1_reg <= en_in;
        end
        if (ready2) begin
            n2_reg  <= n1_reg;
            en2_reg <= en1_reg;
        end
        if (ready3) begin
            n3_reg  <= n2_reg;
            en3_reg <= en2_reg;
        end
    end

    // Keep the normal when any enabled, seeing camera has a negative dot product;
    // a zero dot product does not count, and no camera at all means negate.
    assign facing = |(lane_neg & en3_reg);

    always_ff @(posedge aclk) begin
        if (ready4) begin
            if (facing) begin
                out_data_reg <= {n3_reg[2], n3_reg[1], n3_reg[0]};
            end else begin
                out_data_reg <= {vno_pkg::neg_sat(n3_reg[2]), vno_pkg::neg_sat(n3_reg[1]),
                                 vno_pkg::neg_sat(n3_reg[0])};
            end
            out_rev_reg <= !facing;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_rev_reg;

endmodule

// ----- src/vno_checker.sv -----
// Port-level checker of the viewpoint normal orienter, bound to the top level.
module vno_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // Reset empties the output stage
    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // A stalled result stays offered
    a_stall_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");

    // A stalled result holds its payload
    a_stall_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // A negated normal saturates, so no component can be the most negative code
    a_neg_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000)
                                && (m_tdata[47:32] != 16'h8000))
        else $error("negated component not saturated");

endmodule

bind viewpoint_normal_orienter vno_checker u_vno_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
